// ===== rtl/tsgi_pkg.sv =====
package tsgi_pkg;

  // Register indexes on the configuration port (byte address is four times the index).
  localparam logic [2:0] REG_RESOLUTION = 3'd0;
  localparam logic [2:0] REG_START_YEAR = 3'd1;
  localparam logic [2:0] REG_START_MONTH = 3'd2;
  localparam logic [2:0] REG_START_DAY = 3'd3;
  localparam logic [2:0] REG_START_SOD = 3'd4;
  localparam logic [2:0] REG_STEP_MONTHS = 3'd5;
  localparam logic [2:0] REG_STEP_DAYS = 3'd6;
  localparam logic [2:0] REG_STEP_SECONDS = 3'd7;

  // Resolution codes.
  localparam logic [1:0] RES_YEAR = 2'd0;
  localparam logic [1:0] RES_MONTH = 2'd1;
  localparam logic [1:0] RES_DAY = 2'd2;
  localparam logic [1:0] RES_FINE = 2'd3;

  localparam int MONTHS_PER_YEAR = 12;
  localparam int SECONDS_PER_DAY = 86400;

  // Magnitude of the dividend and width of the divisor.
  localparam int MAG_W = 40;
  localparam int DEN_W = 31;

  typedef struct packed {
    logic neg;
    logic ok;
  } tsgi_side_t;

  function automatic logic [3:0] clamp_month(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd1) r = 4'd1;
    if (m > 4'd12) r = 4'd12;
    return r;
  endfunction

  // Days before the month, counted in a year that starts in March.
  function automatic logic [8:0] days_before(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0: r = 9'd0;
      4'd1: r = 9'd31;
      4'd2: r = 9'd61;
      4'd3: r = 9'd92;
      4'd4: r = 9'd122;
      4'd5: r = 9'd153;
      4'd6: r = 9'd184;
      4'd7: r = 9'd214;
      4'd8: r = 9'd245;
      4'd9: r = 9'd275;
      4'd10: r = 9'd306;
      4'd11: r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Exact floor division by 25 for values below 8192.
  function automatic logic [8:0] div25(input logic [12:0] x);
    logic [25:0] p;
    p = 26'(x) * 26'd5243;
    return p[25:17];
  endfunction

  function automatic logic [23:0] day_number(input logic [13:0] yr, input logic [3:0] mo,
                                             input logic [4:0] dy);
    logic [3:0] m;
    logic [14:0] y;
    logic [3:0] mp;
    m = clamp_month(mo);
    y = {1'b0, yr} + 15'd400;
    if (m <= 4'd2) begin
      y = y - 15'd1;
      mp = m + 4'd9;
    end else begin
      mp = m - 4'd3;
    end
    return 24'(y) * 24'd365 + 24'(y[14:2]) - 24'(div25(y[14:2]))
           + 24'(div25({2'b00, y[14:4]}))
           + 24'(days_before(mp)) + 24'(dy) - 24'd1;
  endfunction

endpackage

// ===== rtl/tsgi_div.sv =====
module tsgi_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [tsgi_pkg::MAG_W-1:0]  in_mag,
  input  logic [tsgi_pkg::DEN_W-1:0]  in_den,
  input  tsgi_pkg::tsgi_side_t        in_side,
  output logic                        out_v,
  output logic [tsgi_pkg::MAG_W-1:0]  out_quo,
  output tsgi_pkg::tsgi_side_t        out_side
);

  localparam int N = tsgi_pkg::MAG_W;
  localparam int D = tsgi_pkg::DEN_W;

  // Stage k holds the partial remainder after k quotient bits.
  logic [N:1] v;
  logic [D-1:0] rem [1:N];
  logic [N-1:0] mag [1:N];
  logic [N-1:0] quo [1:N];
  logic [D-1:0] den [1:N];
  tsgi_pkg::tsgi_side_t side [1:N];

  logic [D-1:0] rem_next [0:N-1];
  logic [N-1:0] bit_next;

  // One restoring step per stage; the first step works on the incoming item.
  always_comb begin
    logic [D:0] trial;
    trial = {{D{1'b0}}, in_mag[N-1]};
    bit_next[0] = trial >= {1'b0, in_den};
    rem_next[0] = bit_next[0] ? D'(trial - {1'b0, in_den}) : D'(trial);
    for (int k = 1; k < N; k++) begin
      trial = {rem[k], mag[k][N-1]};
      bit_next[k] = trial >= {1'b0, den[k]};
      rem_next[k] = bit_next[k] ? D'(trial - {1'b0, den[k]}) : D'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-1:1], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[1] <= rem_next[0];
      mag[1] <= {in_mag[N-2:0], 1'b0};
      quo[1] <= {{(N-1){1'b0}}, bit_next[0]};
      den[1] <= in_den;
      side[1] <= in_side;
      for (int k = 1; k < N; k++) begin
        rem[k+1] <= rem_next[k];
        mag[k+1] <= {mag[k][N-2:0], 1'b0};
        quo[k+1] <= {quo[k][N-2:0], bit_next[k]};
        den[k+1] <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_v = v[N];
  assign out_quo = quo[N];
  assign out_side = side[N];

endmodule

// ===== rtl/timestamp_to_grid_index.sv =====
// Pipeline: the accepting edge loads the first of 46 register stages (five front stages,
// a 40-stage divider that yields one quotient bit per stage, and the output register),
// and out_valid rises when the item reaches the output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous, active high) empties the pipeline and loads the registers
// with resolution day, origin 1970-01-01 00:00:00 and all steps one.
module timestamp_to_grid_index (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         second,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] index,
  output logic               valid_res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers. The user must change them only while the pipeline is empty;
  // the block does not enforce this. Every stage reads them directly.
  logic [1:0]  resolution;
  logic [13:0] start_year;
  logic [3:0]  start_month;
  logic [4:0]  start_day;
  logic [16:0] start_sod;
  logic [11:0] step_months;
  logic [15:0] step_days;
  logic [30:0] step_seconds;

  logic       wr;
  logic [2:0] reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[4:2];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= tsgi_pkg::RES_DAY;
      start_year <= 14'd1970;
      start_month <= 4'd1;
      start_day <= 5'd1;
      start_sod <= '0;
      step_months <= 12'd1;
      step_days <= 16'd1;
      step_seconds <= 31'd1;
    end else if (wr) begin
      case (reg_sel)
        tsgi_pkg::REG_RESOLUTION: resolution <= pwdata[1:0];
        tsgi_pkg::REG_START_YEAR: start_year <= pwdata[13:0];
        tsgi_pkg::REG_START_MONTH: start_month <= pwdata[3:0];
        tsgi_pkg::REG_START_DAY: start_day <= pwdata[4:0];
        tsgi_pkg::REG_START_SOD: start_sod <= pwdata[16:0];
        tsgi_pkg::REG_STEP_MONTHS: step_months <= pwdata[11:0];
        tsgi_pkg::REG_STEP_DAYS: step_days <= pwdata[15:0];
        tsgi_pkg::REG_STEP_SECONDS: step_seconds <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      tsgi_pkg::REG_RESOLUTION: prdata = 32'(resolution);
      tsgi_pkg::REG_START_YEAR: prdata = 32'(start_year);
      tsgi_pkg::REG_START_MONTH: prdata = 32'(start_month);
      tsgi_pkg::REG_START_DAY: prdata = 32'(start_day);
      tsgi_pkg::REG_START_SOD: prdata = 32'(start_sod);
      tsgi_pkg::REG_STEP_MONTHS: prdata = 32'(step_months);
      tsgi_pkg::REG_STEP_DAYS: prdata = 32'(step_days);
      tsgi_pkg::REG_STEP_SECONDS: prdata = 32'(step_seconds);
      default: prdata = '0;
    endcase
  end

  // All stages advance together; they hold only when a finished result is not taken.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // Stage A: the accepted item.
  logic        a_v;
  logic [13:0] a_year;
  logic [3:0]  a_month;
  logic [4:0]  a_day;
  logic [4:0]  a_hour;
  logic [5:0]  a_minute;
  logic [5:0]  a_second;

  // Stage B: day numbers, time of day and the month difference.
  logic               b_v;
  logic [23:0]        b_dn_ts;
  logic [23:0]        b_dn_st;
  logic [16:0]        b_tod;
  logic signed [18:0] b_mon;

  // Stage C: day and second-of-day differences.
  logic               c_v;
  logic signed [24:0] c_dd;
  logic signed [17:0] c_todd;
  logic signed [18:0] c_mon;

  // Stage D: the signed dividend for the resolution in use.
  logic               d_v;
  logic signed [40:0] d_num;

  // Stage E: magnitude, sign and divisor.
  logic                           e_v;
  logic [tsgi_pkg::MAG_W-1:0]     e_mag;
  logic [tsgi_pkg::DEN_W-1:0]     e_den;
  tsgi_pkg::tsgi_side_t           e_side;

  logic signed [14:0] ydiff;
  logic signed [4:0]  mdiff;
  logic signed [18:0] mon_b;
  logic signed [40:0] num_d;
  logic [tsgi_pkg::DEN_W-1:0] den_e;

  always_comb begin
    ydiff = $signed({1'b0, a_year}) - $signed({1'b0, start_year});
    mdiff = $signed({1'b0, tsgi_pkg::clamp_month(a_month)})
            - $signed({1'b0, tsgi_pkg::clamp_month(start_month)});
    mon_b = 19'(ydiff) * 19'(tsgi_pkg::MONTHS_PER_YEAR);
    // Year resolution ignores the months altogether.
    if (resolution == tsgi_pkg::RES_MONTH) mon_b = mon_b + 19'(mdiff);
  end

  always_comb begin
    case (resolution)
      tsgi_pkg::RES_FINE:
        num_d = 41'(c_dd) * 41'(tsgi_pkg::SECONDS_PER_DAY) + 41'(c_todd);
      tsgi_pkg::RES_DAY: num_d = 41'(c_dd);
      default: num_d = 41'(c_mon);
    endcase
  end

  always_comb begin
    case (resolution)
      tsgi_pkg::RES_FINE: den_e = step_seconds;
      tsgi_pkg::RES_DAY: den_e = 31'(step_days);
      default: den_e = 31'(step_months);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
      b_v <= a_v;
      c_v <= b_v;
      d_v <= c_v;
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_year <= year;
      a_month <= month;
      a_day <= day;
      a_hour <= hour;
      a_minute <= minute;
      a_second <= second;

      b_dn_ts <= tsgi_pkg::day_number(a_year, a_month, a_day);
      b_dn_st <= tsgi_pkg::day_number(start_year, start_month, start_day);
      b_tod <= 17'(a_hour) * 17'd3600 + 17'(a_minute) * 17'd60 + 17'(a_second);
      b_mon <= mon_b;

      c_dd <= $signed({1'b0, b_dn_ts}) - $signed({1'b0, b_dn_st});
      c_todd <= $signed({1'b0, b_tod}) - $signed({1'b0, start_sod});
      c_mon <= b_mon;

      d_num <= num_d;

      e_mag <= tsgi_pkg::MAG_W'(d_num[40] ? -d_num : d_num);
      e_den <= den_e;
      e_side.neg <= d_num[40];
      e_side.ok <= den_e != '0;
    end
  end

  logic                       q_v;
  logic [tsgi_pkg::MAG_W-1:0] q_mag;
  tsgi_pkg::tsgi_side_t       q_side;

  tsgi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (e_v),
    .in_mag   (e_mag),
    .in_den   (e_den),
    .in_side  (e_side),
    .out_v    (q_v),
    .out_quo  (q_mag),
    .out_side (q_side)
  );

  // Restore the sign, saturate to 32 bits, and force zero when the step is zero.
  logic [31:0] idx_next;

  always_comb begin
    if (!q_side.ok) begin
      idx_next = '0;
    end else if (q_side.neg) begin
      if (q_mag > tsgi_pkg::MAG_W'(33'h080000000)) idx_next = 32'h80000000;
      else idx_next = 32'(-q_mag);
    end else begin
      if (q_mag > tsgi_pkg::MAG_W'(33'h07FFFFFFF)) idx_next = 32'h7FFFFFFF;
      else idx_next = q_mag[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index <= $signed(idx_next);
      valid_res <= q_side.ok;
    end
  end

endmodule
